FILE: rtl/core/sorted_priority_queue_defines.svh
// Assertion macros for the sorted priority queue.
// Included by the RTL files that carry concurrent checks; needs a clock and reset in scope.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_priority_queue: check failed");

// Next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_priority_queue: check failed");

`endif

FILE: rtl/core/spq_pkg.sv
// Shared constants, codes and types of the sorted priority queue.
// No dependencies; every other file except the assertion macro header imports it.
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 16;
   localparam int PRI_BITS    = 32;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   // One queue slot
   typedef struct packed {
      logic                valid;
      logic [TAG_BITS-1:0] tag;
      logic [PRI_BITS-1:0] pri;
   } entry_type;

   // Broadcast from the top level to every cell
   typedef struct packed {
      logic      enq;
      logic      deq;
      logic      clr;
      entry_type fresh;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/spq_channels.sv
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg.
interface spq_req_if
   import spq_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [1:0]          operation;
   logic [15:0]         item_tag;
   logic signed [31:0]  item_priority;

   modport source (output valid, operation, item_tag, item_priority, input ready);
   modport sink   (input valid, operation, item_tag, item_priority, output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [15:0]         removed_tag;
   logic [15:0]         head_tag;
   logic signed [31:0]  head_priority;
   logic [4:0]          occupancy;
   logic                is_empty;
   logic [1:0]          status;

   modport source (output valid, removed_tag, head_tag, head_priority, occupancy,
                   is_empty, status, input ready);
   modport sink   (input valid, removed_tag, head_tag, head_priority, occupancy,
                   is_empty, status, output ready);
endinterface

FILE: rtl/core/spq_cell.sv
// One slot of the sorted shift chain: holds an entry, compares, and shifts.
// Depends on spq_pkg.
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_entry,
   input  logic          left_gt,
   input  entry_type     right_entry,
   output entry_type     cur_entry,
   output entry_type     nxt_entry,
   output logic          gt
);

   entry_type entry_ff;
   entry_type entry_in;

   // Held entry ranks behind the new item
   assign gt = entry_ff.valid && ($signed(entry_ff.pri) > $signed(ctrl.fresh.pri));

   // Next slot content
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.clr) begin
         entry_in.valid = 1'b0;
      end else if (ctrl.enq) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if ((gt || !entry_ff.valid) && left_entry.valid) begin
            entry_in = ctrl.fresh;
         end
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign cur_entry = entry_ff;
   assign nxt_entry = entry_in;

endmodule

FILE: rtl/core/sorted_priority_queue.sv
// Sorted priority queue: a chain of QUEUE_DEPTH cells kept in ascending priority order.
// The result of an item is offered in the cycle after it is accepted.
// Throughput: one item per cycle while results are taken; the whole chain updates in
// the accept cycle and the response register frees as soon as its item is taken.
// Reset clears the occupancy, all slot valid bits and the response valid; slot
// payloads stay undefined until written.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   cell_ctrl_type ctrl;
   entry_type     cur [QUEUE_DEPTH];
   entry_type     nxt [QUEUE_DEPTH];
   logic          gt  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_valid;
   logic [QUEUE_DEPTH:0]   valid_ext;
   logic                   deq_on_empty;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff;
   logic [15:0]           removed_tag_ff, removed_tag_in;
   logic [15:0]           head_tag_ff, head_tag_in;
   logic [31:0]           head_pri_ff, head_pri_in;
   status_type            status_ff, status_in;

   logic   req_fire;
   logic   full, empty;
   op_type op;

   // Input handshake: take an item whenever the response slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign op             = op_type'(req_chan.operation);
   assign full           = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign empty          = (count_ff == '0);

   // Broadcast control
   always_comb begin
      ctrl.enq         = req_fire && (op == OP_ENQUEUE) && !full;
      ctrl.deq         = req_fire && (op == OP_DEQUEUE) && !empty;
      ctrl.clr         = req_fire && (op == OP_CLEAR);
      ctrl.fresh.valid = 1'b1;
      ctrl.fresh.tag   = req_chan.item_tag[TAG_BITS-1:0];
      ctrl.fresh.pri   = req_chan.item_priority;
   end

   // Cell chain
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_g;
      if (i == 0) begin : g_head
         assign left_e = '{valid: 1'b1, tag: '0, pri: '0};
         assign left_g = 1'b0;
      end else begin : g_body
         assign left_e = cur[i-1];
         assign left_g = gt[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_e = '{valid: 1'b0, tag: '0, pri: '0};
      end else begin : g_mid
         assign right_e = cur[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (left_e),
         .left_gt     (left_g),
         .right_entry (right_e),
         .cur_entry   (cur[i]),
         .nxt_entry   (nxt[i]),
         .gt          (gt[i])
      );
      assign cell_valid[i] = cur[i].valid;
   end

   // Occupancy and response contents
   always_comb begin
      count_in       = count_ff;
      removed_tag_in = '0;
      status_in      = ST_OK;
      priority if (ctrl.clr) begin
         count_in = '0;
      end else if (ctrl.enq) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (ctrl.deq) begin
         count_in       = count_ff - COUNT_BITS'(1);
         removed_tag_in = 16'(cur[0].tag);
      end
      unique case (op)
         OP_ENQUEUE: if (full) status_in = ST_FULL;
         OP_DEQUEUE: if (empty) status_in = ST_EMPTY;
         OP_CLEAR:   status_in = ST_OK;
         default:    status_in = ST_OK;
      endcase
      if (count_in == '0) begin
         head_tag_in = '0;
         head_pri_in = '0;
      end else begin
         head_tag_in = 16'(nxt[0].tag);
         head_pri_in = nxt[0].pri;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         removed_tag_ff <= removed_tag_in;
         head_tag_ff    <= head_tag_in;
         head_pri_ff    <= head_pri_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.removed_tag   = removed_tag_ff;
   assign rsp_chan.head_tag      = head_tag_ff;
   assign rsp_chan.head_priority = head_pri_ff;
   assign rsp_chan.occupancy     = 5'(count_ff);
   assign rsp_chan.is_empty      = (count_ff == '0);
   assign rsp_chan.status        = status_ff;

   // Check terms
   assign valid_ext    = {1'b0, cell_valid};
   assign deq_on_empty = req_fire && (op == OP_DEQUEUE) && empty;

   // Checks: valid bits match the count and stay packed at the head; a dequeue on empty reports ST_EMPTY
   `SPQ_ASSERT_NOW(a_count_matches, 1'b1, $countones(cell_valid) == 32'(count_ff))
   `SPQ_ASSERT_NOW(a_valid_packed, 1'b1, ((valid_ext + 1'b1) & valid_ext) == '0)
   `SPQ_ASSERT_NEXT(a_deq_empty, deq_on_empty, rsp_valid_ff && (status_ff == ST_EMPTY) && empty)

endmodule

FILE: tb/sv/sorted_priority_queue_tb.sv
// Self-checking testbench for sorted_priority_queue: drives request items, predicts every
// response with its own sorted-queue model and compares it field by field.
// Depends on spq_pkg and the spq_req_if / spq_rsp_if interfaces.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
   import spq_pkg::*;

   // Operation code that the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int HOLD_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 382;
   localparam int PRINT_CAP      = 50;

   typedef struct {
      logic [1:0]         op;
      logic [15:0]        tag;
      logic signed [31:0] pri;
   } spq_request_type;

   typedef struct {
      logic [15:0]        removed_tag;
      logic [15:0]        head_tag;
      logic signed [31:0] head_pri;
      logic [4:0]         occupancy;
      logic               is_empty;
      status_type         status;
   } spq_outcome_type;

   logic clock;
   logic reset;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   sorted_priority_queue u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Stimulus and expectation stores
   spq_request_type pending_items[$];
   spq_outcome_type expected_results[$];
   spq_request_type current_item;
   spq_outcome_type want_rsp;

   // Shadow copy of the queue contents
   logic [15:0]        shadow_tags [QUEUE_DEPTH];
   logic signed [31:0] shadow_pris [QUEUE_DEPTH];
   int                 shadow_count = 0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_request   = 1'b0;
   int hold_left      = 0;
   int idle_cycles    = 0;

   int error_count     = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int full_refusals   = 0;
   int empty_dequeues  = 0;
   int clears_seen     = 0;
   int generated       = 0;

   // Clock and reset
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Known values on every input from time zero
   initial begin
      req_chan.valid         = 1'b0;
      req_chan.operation     = OP_ENQUEUE;
      req_chan.item_tag      = '0;
      req_chan.item_priority = '0;
      rsp_chan.ready         = 1'b0;
   end

   task automatic report_error(input string msg);
      if (error_count < PRINT_CAP)
         $display("ERROR [%0t] %s", $realtime, msg);
      error_count++;
   endtask

   // Applies one item to the shadow queue and returns the response it should give
   function automatic spq_outcome_type apply_to_shadow(input spq_request_type it);
      spq_outcome_type r;
      int pos;
      int i;
      bit found;
      r.removed_tag = '0;
      r.status      = ST_OK;
      case (it.op)
         OP_ENQUEUE: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
               full_refusals++;
            end else begin
               // new entry goes behind every entry of lower or equal priority
               pos   = shadow_count;
               found = 1'b0;
               for (i = 0; i < shadow_count; i++) begin
                  if (!found && shadow_pris[i] > it.pri) begin
                     pos   = i;
                     found = 1'b1;
                  end
               end
               for (i = shadow_count; i > pos; i--) begin
                  shadow_tags[i] = shadow_tags[i-1];
                  shadow_pris[i] = shadow_pris[i-1];
               end
               shadow_tags[pos] = it.tag;
               shadow_pris[pos] = it.pri;
               shadow_count++;
            end
         end
         OP_DEQUEUE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
               empty_dequeues++;
            end else begin
               r.removed_tag = shadow_tags[0];
               for (i = 1; i < shadow_count; i++) begin
                  shadow_tags[i-1] = shadow_tags[i];
                  shadow_pris[i-1] = shadow_pris[i];
               end
               shadow_count--;
            end
         end
         OP_CLEAR: begin
            shadow_count = 0;
            clears_seen++;
         end
         default: ;
      endcase
      if (shadow_count != 0) begin
         r.head_tag = shadow_tags[0];
         r.head_pri = shadow_pris[0];
      end else begin
         r.head_tag = '0;
         r.head_pri = '0;
      end
      r.occupancy = shadow_count[4:0];
      r.is_empty  = (shadow_count == 0);
      return r;
   endfunction

   // Driver: offers pending items, records the prediction on each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_results.push_back(apply_to_shadow(current_item));
            items_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               current_item            = pending_items.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.operation     <= current_item.op;
               req_chan.item_tag      <= current_item.tag;
               req_chan.item_priority <= current_item.pri;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted down on its own
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left   <= HOLD_CYCLES;
      end
   end

   // Monitor: checks each taken response against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               report_error("response with no item outstanding");
            end else begin
               want_rsp = expected_results.pop_front();
               if (rsp_chan.removed_tag !== want_rsp.removed_tag)
                  report_error($sformatf("rsp %0d removed_tag %h, want %h", results_checked,
                     rsp_chan.removed_tag, want_rsp.removed_tag));
               if (rsp_chan.head_tag !== want_rsp.head_tag)
                  report_error($sformatf("rsp %0d head_tag %h, want %h", results_checked,
                     rsp_chan.head_tag, want_rsp.head_tag));
               if (rsp_chan.head_priority !== want_rsp.head_pri)
                  report_error($sformatf("rsp %0d head_priority %h, want %h", results_checked,
                     rsp_chan.head_priority, want_rsp.head_pri));
               if (rsp_chan.occupancy !== want_rsp.occupancy)
                  report_error($sformatf("rsp %0d occupancy %0d, want %0d", results_checked,
                     rsp_chan.occupancy, want_rsp.occupancy));
               if (rsp_chan.is_empty !== want_rsp.is_empty)
                  report_error($sformatf("rsp %0d is_empty %b, want %b", results_checked,
                     rsp_chan.is_empty, want_rsp.is_empty));
               if (rsp_chan.status !== want_rsp.status)
                  report_error($sformatf("rsp %0d status %0d, want %0d", results_checked,
                     rsp_chan.status, want_rsp.status));
               results_checked++;
            end
         end
         // held off during a long stretch, otherwise random stalls
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: ends the run when no handshake happens for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_item(input logic [1:0] op, input logic [15:0] tag,
                            input logic signed [31:0] pri);
      spq_request_type it;
      it.op  = op;
      it.tag = tag;
      it.pri = pri;
      pending_items.push_back(it);
      generated++;
   endtask

   // Priorities biased toward ties and extremes
   function automatic logic signed [31:0] rand_priority();
      int v;
      case ($urandom_range(7))
         0, 1, 2: begin
            v = int'($urandom_range(4)) - 2;
            return v * 65536;
         end
         3, 4: return $urandom;
         5: begin
            case ($urandom_range(3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0000_0000;
               default: return 32'shFFFF_FFFF;
            endcase
         end
         default: begin
            v = int'($urandom_range(1023)) - 512;
            return v;
         end
      endcase
   endfunction

   // Mostly fill and drain runs, with mixed traffic, clears and ignored codes
   task automatic gen_traffic(input int n_items);
      int target;
      int k;
      int j;
      int r;
      target = generated + n_items;
      while (generated < target) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               k = $urandom_range(QUEUE_DEPTH - 4, QUEUE_DEPTH + 4);
               for (j = 0; j < k; j++) push_item(OP_ENQUEUE, 16'($urandom), rand_priority());
               k = $urandom_range(4, QUEUE_DEPTH + 3);
               for (j = 0; j < k; j++) push_item(OP_DEQUEUE, 16'($urandom), $urandom);
            end
            4, 5, 6: begin
               for (j = 0; j < 8; j++) begin
                  r = $urandom_range(99);
                  if (r < 48)      push_item(OP_ENQUEUE, 16'($urandom), rand_priority());
                  else if (r < 88) push_item(OP_DEQUEUE, 16'($urandom), $urandom);
                  else if (r < 94) push_item(OP_CLEAR, 16'($urandom), $urandom);
                  else             push_item(OP_UNUSED, 16'($urandom), $urandom);
               end
            end
            7: push_item(OP_CLEAR, 16'($urandom), $urandom);
            8: push_item(OP_UNUSED, 16'($urandom), $urandom);
            default: begin
               k = $urandom_range(3, 6);
               for (j = 0; j < k; j++) push_item(OP_DEQUEUE, 16'($urandom), $urandom);
            end
         endcase
      end
   endtask

   // Sender pause: wait until every item is taken and every response checked
   task automatic wait_drained();
      do @(posedge clock);
      while (!(pending_items.size() == 0 && !req_chan.valid && expected_results.size() == 0));
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Main sequence
   initial begin
      int i;
      reset = 1'b1;

      // directed: empty dequeue, ignored code, extremes, ties, full refusal, clear
      push_item(OP_DEQUEUE, 16'h0000, 32'sh0);
      push_item(OP_UNUSED, 16'hFFFF, 32'sh7FFF_FFFF);
      push_item(OP_ENQUEUE, 16'hFFFF, 32'sh7FFF_FFFF);
      push_item(OP_ENQUEUE, 16'h0000, 32'sh8000_0000);
      push_item(OP_ENQUEUE, 16'h0001, 32'sh0);
      push_item(OP_ENQUEUE, 16'h0002, 32'sh0);
      for (i = 0; i < QUEUE_DEPTH - 4; i++)
         push_item(OP_ENQUEUE, 16'(16'h0100 + i), (i % 3 - 1) * 65536);
      push_item(OP_ENQUEUE, 16'hAAAA, 32'sh8000_0000);
      push_item(OP_DEQUEUE, 16'h5555, 32'sh1234_5678);
      push_item(OP_DEQUEUE, 16'h5555, 32'sh1234_5678);
      push_item(OP_CLEAR, 16'hFFFF, 32'shFFFF_FFFF);
      push_item(OP_DEQUEUE, 16'h0000, 32'sh0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait_drained();

      // no idling, with one long receiver hold-off so the input backs up
      set_idling(0, 0);
      gen_traffic(PHASE_ITEMS);
      hold_request = 1'b1;
      wait_drained();

      set_idling(66, 0);
      gen_traffic(PHASE_ITEMS);
      wait_drained();

      set_idling(0, 66);
      gen_traffic(PHASE_ITEMS);
      wait_drained();

      set_idling(36, 36);
      gen_traffic(PHASE_ITEMS);
      wait_drained();

      repeat (8) @(posedge clock);
      if (expected_results.size() != 0)
         report_error($sformatf("%0d responses never arrived", expected_results.size()));

      $display("Covered %0d items and %0d responses over four idling patterns.",
         items_accepted, results_checked);
      $display("Full refusals %0d, dequeues on empty %0d, clears %0d.",
         full_refusals, empty_dequeues, clears_seen);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
